>>> hw/rtl/spf_pkg.sv
// Shared constants and types for the stepper position follower.
package spf_pkg;

	// Field widths
	localparam int PULSE_W   = 12;
	localparam int STEPS_W   = 16;
	localparam int POS_OUT_W = 16;

	// Default width of the internal position counters
	localparam int POSITION_WIDTH_DEF = 16;

	// Scaling and travel constants
	localparam logic [PULSE_W-1:0] PULSE_FLOOR = 12'd988;
	localparam int                 SCALE_SHIFT = 10;   // divide by 1024
	localparam int                 HALF_REV    = 1600;
	localparam int                 FULL_REV    = 3200;
	localparam logic [STEPS_W-1:0] STEPS_RESET = 16'd3200;

	// Motion state, one-hot
	typedef enum logic [5:0] {
		MODE_INIT       = 6'b000001,
		MODE_OFF        = 6'b000010,
		MODE_DOWN       = 6'b000100,
		MODE_DOWN_START = 6'b001000,
		MODE_UP         = 6'b010000,
		MODE_UP_START   = 6'b100000
	} mode_t;

	// One result beat
	typedef struct packed {
		logic                 direction;
		logic                 step_pulse;
		logic [POS_OUT_W-1:0] position;
		logic                 moving;
	} result_t;

endpackage

>>> hw/rtl/spf_if.sv
// Valid/ready channel interfaces for pulse input and result output.
interface spf_pulse_if;
	logic                        valid;
	logic                        ready;
	logic [spf_pkg::PULSE_W-1:0] pulse_value;

	modport source (output valid, output pulse_value, input ready);
	modport sink   (input valid, input pulse_value, output ready);
endinterface

interface spf_result_if;
	logic                          valid;
	logic                          ready;
	logic                          direction;
	logic                          step_pulse;
	logic [spf_pkg::POS_OUT_W-1:0] position;
	logic                          moving;

	modport source (output valid, output direction, output step_pulse, output position,
		output moving, input ready);
	modport sink   (input valid, input direction, input step_pulse, input position,
		input moving, output ready);
endinterface

>>> hw/rtl/stepper_position_follower.sv
// Top level of the stepper position follower.
//
//   channel  dir  beat                                    handshake
//   pulse    in   pulse_value[11:0]                       valid/ready
//   result   out  direction, step_pulse, position, moving  valid/ready
//   cfg      in   steps_per_rev[15:0]                     cfg_wen, no ready
//
// One beat in, one beat out. A pulse beat sits in the input register
// until it advances; then the motion state and target update together and
// the result lands in the output register, one beat per cycle while the
// result is not stalled. The throughput is set by the state update loop.
// Reset puts the motion state in Init at position 3200, steps_per_rev 3200.
// A stalled result holds the input register; pulse accepts while it is free.
module stepper_position_follower #(
	parameter int POSITION_WIDTH = spf_pkg::POSITION_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [spf_pkg::STEPS_W-1:0] cfg_wdata,
	spf_pulse_if.sink                   pulse,
	spf_result_if.source                result
);

	logic [spf_pkg::STEPS_W-1:0] steps_q;
	logic [spf_pkg::PULSE_W-1:0] pulse_s1;
	logic                        valid_s1;
	logic                        valid_s2;
	logic                        advance;
	logic [POSITION_WIDTH-1:0]   target_next;
	spf_pkg::result_t            res_s2;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= spf_pkg::STEPS_RESET;
		end else if (cfg_wen) begin
			steps_q <= cfg_wdata;
		end
	end

	// Flow control
	assign advance     = valid_s1 && (!valid_s2 || result.ready);
	assign pulse.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pulse.valid && pulse.ready) valid_s1 <= 1'b1;
			else if (advance)              valid_s1 <= 1'b0;
			if (advance)                   valid_s2 <= 1'b1;
			else if (result.ready)         valid_s2 <= 1'b0;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (pulse.valid && pulse.ready) pulse_s1 <= pulse.pulse_value;
	end

	spf_target #(.POSITION_WIDTH(POSITION_WIDTH)) u_target (
		.pulse_value   (pulse_s1),
		.steps_per_rev (steps_q),
		.target        (target_next)
	);

	spf_motion #(.POSITION_WIDTH(POSITION_WIDTH)) u_motion (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.target_next (target_next),
		.res_s2      (res_s2)
	);

	// Output beat
	assign result.valid      = valid_s2;
	assign result.direction  = res_s2.direction;
	assign result.step_pulse = res_s2.step_pulse;
	assign result.position   = res_s2.position;
	assign result.moving     = res_s2.moving;

endmodule

>>> hw/rtl/spf_target.sv
// Scales a servo pulse value to a target position count.
module spf_target #(
	parameter int POSITION_WIDTH = spf_pkg::POSITION_WIDTH_DEF
) (
	input  logic [spf_pkg::PULSE_W-1:0] pulse_value,
	input  logic [spf_pkg::STEPS_W-1:0] steps_per_rev,
	output logic [POSITION_WIDTH-1:0]   target
);

	localparam int PROD_W   = spf_pkg::PULSE_W + spf_pkg::STEPS_W;
	localparam int SCALED_W = PROD_W - spf_pkg::SCALE_SHIFT;
	localparam int SUM_W    = SCALED_W + 1;

	logic [spf_pkg::PULSE_W-1:0] pulse_sat;
	logic [spf_pkg::PULSE_W-1:0] offset;
	logic [PROD_W-1:0]           prod;
	logic [SCALED_W-1:0]         scaled;
	logic [SUM_W-1:0]            sum;

	// Saturate low pulses, scale, center on half a revolution
	always_comb begin
		pulse_sat = (pulse_value < spf_pkg::PULSE_FLOOR) ? spf_pkg::PULSE_FLOOR : pulse_value;
		offset    = pulse_sat - spf_pkg::PULSE_FLOOR;
		prod      = PROD_W'(offset) * PROD_W'(steps_per_rev);
		scaled    = prod[PROD_W-1:spf_pkg::SCALE_SHIFT];
		sum       = SUM_W'(scaled) + SUM_W'(spf_pkg::HALF_REV);
		target    = POSITION_WIDTH'(sum);
	end

endmodule

>>> hw/rtl/spf_motion.sv
// Motion state machine: direction choice, stepping and the result register.
module spf_motion #(
	parameter int POSITION_WIDTH = spf_pkg::POSITION_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [POSITION_WIDTH-1:0] target_next,
	output spf_pkg::result_t          res_s2
);

	localparam logic [POSITION_WIDTH-1:0] HALF = POSITION_WIDTH'(spf_pkg::HALF_REV);
	localparam logic [POSITION_WIDTH-1:0] FULL = POSITION_WIDTH'(spf_pkg::FULL_REV);

	spf_pkg::mode_t            mode_q, mode_n;
	logic [POSITION_WIDTH-1:0] act_q, act_n;
	logic [POSITION_WIDTH-1:0] tgt_q;
	logic                      dir_q, dir_n;
	logic                      step;

	// Next state for one tick
	always_comb begin
		mode_n = mode_q;
		act_n  = act_q;
		dir_n  = dir_q;
		step   = 1'b0;
		unique case (mode_q)
			spf_pkg::MODE_INIT: begin
				mode_n = spf_pkg::MODE_OFF;
			end
			spf_pkg::MODE_DOWN_START: begin
				dir_n  = 1'b1;
				mode_n = spf_pkg::MODE_DOWN;
			end
			spf_pkg::MODE_DOWN: begin
				step  = 1'b1;
				act_n = act_q - 1'b1;
				if (tgt_q >= act_n) mode_n = spf_pkg::MODE_OFF;
			end
			spf_pkg::MODE_UP_START: begin
				dir_n  = 1'b0;
				mode_n = spf_pkg::MODE_UP;
			end
			spf_pkg::MODE_UP: begin
				step  = 1'b1;
				act_n = act_q + 1'b1;
				if (tgt_q <= act_n) mode_n = spf_pkg::MODE_OFF;
			end
			default: begin
				// Off (and any stray code): pick the shorter way round
				mode_n = spf_pkg::MODE_OFF;
				if (tgt_q < act_q) begin
					if ((act_q - tgt_q) > HALF && act_q > FULL) begin
						act_n  = act_q - FULL;
						mode_n = spf_pkg::MODE_UP_START;
					end else begin
						mode_n = spf_pkg::MODE_DOWN_START;
					end
				end else if (tgt_q > act_q) begin
					if ((tgt_q - act_q) > HALF && act_q < FULL) begin
						act_n  = act_q + FULL;
						mode_n = spf_pkg::MODE_DOWN_START;
					end else begin
						mode_n = spf_pkg::MODE_UP_START;
					end
				end
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= spf_pkg::MODE_INIT;
			act_q  <= FULL;
			tgt_q  <= FULL;
			dir_q  <= 1'b0;
		end else if (en) begin
			mode_q <= mode_n;
			act_q  <= act_n;
			tgt_q  <= target_next;
			dir_q  <= dir_n;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (en) begin
			res_s2.direction  <= dir_n;
			res_s2.step_pulse <= step;
			res_s2.position   <= spf_pkg::POS_OUT_W'(act_n);
			res_s2.moving     <= (mode_n != spf_pkg::MODE_OFF);
		end
	end

endmodule

>>> hw/rtl/spf_checker.sv
// Port-level checks for the stepper position follower, bound to the top level.
module spf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic                          direction,
	input logic                          step_pulse,
	input logic [spf_pkg::POS_OUT_W-1:0] position,
	input logic                          moving
);

	logic                          seen_q;
	logic                          prev_moving_q;
	logic                          prev_dir_q;
	logic [spf_pkg::POS_OUT_W-1:0] prev_pos_q;
	logic                          res_beat;

	assign res_beat = res_valid && res_ready;

	// Remember the last delivered result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= 1'b0;
			prev_moving_q <= 1'b0;
			prev_dir_q    <= 1'b0;
			prev_pos_q    <= '0;
		end else if (res_beat) begin
			seen_q        <= 1'b1;
			prev_moving_q <= moving;
			prev_dir_q    <= direction;
			prev_pos_q    <= position;
		end
	end

	// A stalled result beat stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	// A step only follows a moving beat
	a_step_after_moving: assert property (@(posedge clk) disable iff (!arst_n)
		res_beat && step_pulse |-> seen_q && prev_moving_q)
		else $error("step without prior motion");

	// A step moves the position by one in the set direction
	a_step_delta: assert property (@(posedge clk) disable iff (!arst_n)
		res_beat && step_pulse && seen_q |->
			position == (direction ? prev_pos_q - 1'b1 : prev_pos_q + 1'b1))
		else $error("step did not move position by one");

	// Direction does not change on a stepping beat
	a_step_dir: assert property (@(posedge clk) disable iff (!arst_n)
		res_beat && step_pulse && seen_q |-> direction == prev_dir_q)
		else $error("direction changed while stepping");

endmodule

bind stepper_position_follower spf_checker u_spf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.direction  (result.direction),
	.step_pulse (result.step_pulse),
	.position   (result.position),
	.moving     (result.moving)
);

>>> bench/tb_stepper_position_follower.sv
// Self-checking bench for the stepper position follower: tick beats in, motion results out.
module tb_stepper_position_follower;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 4;

	// Fixed pulse values: field extremes, the saturation floor and the nominal span
	localparam logic [spf_pkg::PULSE_W-1:0] EDGE_PULSES [10] = '{
		12'd0, 12'd4095, 12'd987, 12'd988, 12'd989,
		12'd2012, 12'd2013, 12'd1500, 12'h555, 12'hAAA
	};
	// 1989 with the widest scale wraps the target down to 127
	localparam logic [spf_pkg::PULSE_W-1:0] WIDE_PULSES [4] =
		'{12'd4095, 12'd1989, 12'd3000, 12'd988};
	localparam logic [spf_pkg::PULSE_W-1:0] FLAT_PULSES [3] = '{12'd4095, 12'd0, 12'd2000};

	// Tracks the follower's motion state and queues the result beat each tick produces
	class follower_scoreboard;
		spf_pkg::mode_t              mode;
		logic [15:0]                 pos;
		logic [15:0]                 goal;
		logic                        dir_line;
		logic [spf_pkg::STEPS_W-1:0] steps;
		spf_pkg::result_t            motion_beats[$];
		int                          errors;
		int                          beats_checked;

		function new();
			mode          = spf_pkg::MODE_INIT;
			pos           = 16'(spf_pkg::FULL_REV);
			goal          = 16'(spf_pkg::FULL_REV);
			dir_line      = 1'b0;
			steps         = spf_pkg::STEPS_RESET;
			errors        = 0;
			beats_checked = 0;
		endfunction

		// Scaled target for a pulse under the current steps setting
		function logic [15:0] target_for(input logic [spf_pkg::PULSE_W-1:0] p);
			logic [31:0] span;
			span = (p < spf_pkg::PULSE_FLOOR) ? 32'd0 : 32'(p - spf_pkg::PULSE_FLOOR);
			return 16'(((span * 32'(steps)) >> spf_pkg::SCALE_SHIFT) +
				32'(spf_pkg::HALF_REV));
		endfunction

		// Off state: go the short way round, shifting by one revolution if needed
		function void pick_direction();
			if (goal < pos) begin
				if ((pos - goal) > spf_pkg::HALF_REV && pos > spf_pkg::FULL_REV) begin
					pos  = pos - 16'(spf_pkg::FULL_REV);
					mode = spf_pkg::MODE_UP_START;
				end else begin
					mode = spf_pkg::MODE_DOWN_START;
				end
			end else if (goal > pos) begin
				if ((goal - pos) > spf_pkg::HALF_REV && pos < spf_pkg::FULL_REV) begin
					pos  = pos + 16'(spf_pkg::FULL_REV);
					mode = spf_pkg::MODE_DOWN_START;
				end else begin
					mode = spf_pkg::MODE_UP_START;
				end
			end
		endfunction

		// One tick: state machine first, then the new target
		function void take_pulse(input logic [spf_pkg::PULSE_W-1:0] p);
			spf_pkg::result_t r;
			logic             stepped;
			stepped = 1'b0;
			case (mode)
				spf_pkg::MODE_INIT: mode = spf_pkg::MODE_OFF;
				spf_pkg::MODE_DOWN_START: begin
					dir_line = 1'b1;
					mode     = spf_pkg::MODE_DOWN;
				end
				spf_pkg::MODE_DOWN: begin
					stepped = 1'b1;
					pos     = pos - 16'd1;
					if (goal >= pos)
						mode = spf_pkg::MODE_OFF;
				end
				spf_pkg::MODE_UP_START: begin
					dir_line = 1'b0;
					mode     = spf_pkg::MODE_UP;
				end
				spf_pkg::MODE_UP: begin
					stepped = 1'b1;
					pos     = pos + 16'd1;
					if (goal <= pos)
						mode = spf_pkg::MODE_OFF;
				end
				default: begin
					mode = spf_pkg::MODE_OFF;
					pick_direction();
				end
			endcase
			goal         = target_for(p);
			r.direction  = dir_line;
			r.step_pulse = stepped;
			r.position   = pos;
			r.moving     = (mode != spf_pkg::MODE_OFF);
			motion_beats.push_back(r);
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 40)
				$display("MISMATCH: %0s", msg);
		endtask

		task check_beat(input spf_pkg::result_t got);
			spf_pkg::result_t want;
			if (motion_beats.size() == 0) begin
				report("result beat with no tick outstanding");
				return;
			end
			want = motion_beats.pop_front();
			beats_checked++;
			if (got.direction !== want.direction)
				report($sformatf("beat %0d direction: want %0b got %0b",
					beats_checked, want.direction, got.direction));
			if (got.step_pulse !== want.step_pulse)
				report($sformatf("beat %0d step_pulse: want %0b got %0b",
					beats_checked, want.step_pulse, got.step_pulse));
			if (got.position !== want.position)
				report($sformatf("beat %0d position: want %0d got %0d",
					beats_checked, want.position, got.position));
			if (got.moving !== want.moving)
				report($sformatf("beat %0d moving: want %0b got %0b",
					beats_checked, want.moving, got.moving));
		endtask
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_wen;
	logic [spf_pkg::STEPS_W-1:0] cfg_wdata;
	int                          cycles;
	int                          tx_stretch;
	bit                          tx_calm;

	spf_pulse_if  pulse_ch ();
	spf_result_if result_ch ();

	follower_scoreboard sb = new();

	stepper_position_follower dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.pulse     (pulse_ch),
		.result    (result_ch)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_stepper_position_follower: errors");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then long
	function automatic int idle_cycles(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one tick beat after an optional gap; returns at the accepting edge
	task automatic send_pulse(input logic [spf_pkg::PULSE_W-1:0] p);
		int gap;
		if (tx_stretch == 0) begin
			tx_stretch = $urandom_range(20, 80);
			tx_calm    = ($urandom_range(0, 99) < 30);
		end
		tx_stretch--;
		gap = idle_cycles(tx_calm);
		if (gap > 0) begin
			pulse_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pulse_ch.valid       <= 1'b1;
		pulse_ch.pulse_value <= p;
		do
			@(posedge clk);
		while (!pulse_ch.ready);
		sb.take_pulse(p);
	endtask

	// Drain the block, then write the scale register
	task automatic reconfigure(input logic [spf_pkg::STEPS_W-1:0] v);
		pulse_ch.valid <= 1'b0;
		while (sb.motion_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen  <= 1'b0;
		sb.steps = v;
	endtask

	// Pulse whose target lies lo..hi steps from the position; with wrap set,
	// only targets that trigger the one-revolution shift qualify
	function automatic void find_pulse(input int lo, input int hi, input bit wrap,
		output logic [spf_pkg::PULSE_W-1:0] p, output int travel);
		logic [spf_pkg::PULSE_W-1:0] hits[$];
		int                          here;
		int                          d;
		int                          ad;
		here = int'(sb.pos);
		for (int c = 0; c < 4096; c++) begin
			d  = int'(sb.target_for(12'(c))) - here;
			ad = (d < 0) ? -d : d;
			if (ad < lo || ad > hi)
				continue;
			if (wrap && !((d < 0) ? (here > spf_pkg::FULL_REV) : (here < spf_pkg::FULL_REV)))
				continue;
			hits.push_back(12'(c));
		end
		if (hits.size() == 0) begin
			p      = 12'($urandom_range(0, 4095));
			travel = 0;
			return;
		end
		p      = hits[$urandom_range(0, hits.size() - 1)];
		d      = int'(sb.target_for(p)) - here;
		ad     = (d < 0) ? -d : d;
		travel = wrap ? (spf_pkg::FULL_REV - ad) : ad;
	endfunction

	// Random moves: hold a pulse long enough for the motor to arrive, up to a cap,
	// mixed with cut-short moves and single noise ticks
	task automatic run_moves(input int count);
		int                          sent;
		int                          kind;
		int                          hold;
		int                          travel;
		logic [spf_pkg::PULSE_W-1:0] p;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				p    = 12'($urandom_range(0, 4095));
				hold = 1;
			end else begin
				if (kind < 50)
					find_pulse(0, 40, 1'b0, p, travel);
				else if (kind < 75)
					find_pulse(41, 400, 1'b0, p, travel);
				else
					find_pulse(3100, 3199, 1'b1, p, travel);
				hold = travel + $urandom_range(3, 5);
				if ($urandom_range(0, 99) < 15)
					hold = $urandom_range(1, 2);
				if (hold > 120)
					hold = 120;
			end
			for (int i = 0; i < hold && sent < count; i++) begin
				send_pulse(p);
				sent++;
			end
		end
	endtask

	// Result side: random stalls, one long hold-off to back up the input
	initial begin
		spf_pkg::result_t got;
		int               stall;
		int               rx_stretch;
		bit               rx_calm;
		bit               pressure_done;
		stall         = 0;
		rx_stretch    = 0;
		rx_calm       = 1'b0;
		pressure_done = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got.direction  = result_ch.direction;
				got.step_pulse = result_ch.step_pulse;
				got.position   = result_ch.position;
				got.moving     = result_ch.moving;
				sb.check_beat(got);
				if (rx_stretch == 0) begin
					rx_stretch = $urandom_range(20, 80);
					rx_calm    = ($urandom_range(0, 99) < 30);
				end
				rx_stretch--;
				stall = idle_cycles(rx_calm);
				if (!pressure_done && sb.beats_checked == 150) begin
					stall         = 120;
					pressure_done = 1'b1;
				end
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Main sequence
	initial begin
		arst_n               <= 1'b0;
		cfg_wen              <= 1'b0;
		cfg_wdata            <= '0;
		pulse_ch.valid       <= 1'b0;
		pulse_ch.pulse_value <= '0;
		result_ch.ready      <= 1'b0;
		cycles               <= 0;
		tx_stretch           = 0;
		tx_calm              = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset scale
		foreach (EDGE_PULSES[i])
			send_pulse(EDGE_PULSES[i]);
		run_moves(110);

		// Widest scale: targets wrap
		reconfigure(16'hFFFF);
		foreach (WIDE_PULSES[i])
			send_pulse(WIDE_PULSES[i]);
		run_moves(110);

		// Narrowest nonzero scale
		reconfigure(16'd1);
		run_moves(70);

		// Zero scale: target pinned at half a revolution
		reconfigure(16'd0);
		foreach (FLAT_PULSES[i])
			send_pulse(FLAT_PULSES[i]);
		run_moves(40);

		reconfigure(16'd3200);
		run_moves(110);

		reconfigure(16'($urandom_range(2, 65534)));
		run_moves(110);

		// Drain and let any stray beat show up
		pulse_ch.valid <= 1'b0;
		while (sb.motion_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_stepper_position_follower: clean");
		else
			$display("tb_stepper_position_follower: errors");
		$finish;
	end

endmodule
